// ===== src/stl_pkg.sv =====
// Shared types, codes and character-class helpers for the source token lexer.
// Depends on nothing; used by source_token_lexer.
package stl_pkg;

    // Default width of the character offset counter.
    localparam int POSITION_BITS_DEF = 32;

    // Depth of the token record queue (one character can yield three records).
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Most records one character can produce.
    localparam int MAX_RESULTS = 3;

    localparam logic [31:0] LEN_SAT = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        K_IDENT  = 3'd0,
        K_NUMBER = 3'd1,
        K_STRING = 3'd2,
        K_OPER   = 3'd3,
        K_END    = 3'd4,
        K_BADSTR = 3'd5,
        K_BADCMT = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [7:0]  op;
        logic        last;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return c inside {[8'h30:8'h37]};
    endfunction

    // Lowercase hex letters only.
    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h66]};
    endfunction

    // Single-character operators.
    function automatic logic is_oper(input logic [7:0] c);
        return c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2E, 8'h2C, 8'h3B,
                         8'h3A, 8'h3D, 8'h7C, 8'h26, 8'h2B, 8'h2A, 8'h2D, 8'h2F, 8'h25,
                         8'h23, 8'h40, 8'h21, 8'h3F, 8'h5E, 8'h3C, 8'h3E, 8'h5C};
    endfunction

    // Characters that end an identifier: operators plus space, tab, LF, CR, '$', '~'.
    function automatic logic is_term(input logic [7:0] c);
        return is_oper(c) || (c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h24, 8'h7E});
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == LEN_SAT) ? v : v + 32'd1;
    endfunction

endpackage

// ===== src/source_token_lexer.sv =====
// Top level of the source token lexer: character classification, lexer state
// and the token record queue. Depends on stl_pkg.
//
// The lexer takes one source character per word on the slave stream and emits
// token records on the master stream. A character is taken in every cycle as
// long as at most one record is waiting in the output queue, so plain text
// runs at one character per cycle. Output moves one record per cycle while ready;
// a character that closes a token and opens another operator, or the final
// character (which adds end-of-input), can produce two or three records, and
// the input stalls for the extra cycles those records need to drain. The last
// character of a source is flagged with tlast; after it the lexer is back in its
// reset state and the next character starts a new source at offset 0. Offsets
// count in POSITION_BITS bits and wrap; lengths saturate at all ones. The
// record tlast marks the last record caused by one input character.
module source_token_lexer #(
    parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: characters
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,   // final_char
    // master stream: token records
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [31:0] token_start, [63:32] token_length,
                                          // [71:64] operator_char
    output logic [2:0]  o_m_axis_tuser,   // [2:0] token_kind
    output logic        o_m_axis_tlast    // run_end
);

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_SLASH  = 4'd1,
        M_LINE   = 4'd2,
        M_BLOCK  = 4'd3,
        M_STRING = 4'd4,
        M_IDENT  = 4'd5,
        M_ZERO   = 4'd6,
        M_HEX    = 4'd7,
        M_BIN    = 4'd8,
        M_OCT    = 4'd9,
        M_DEC    = 4'd10,
        M_TAIL   = 4'd11
    } t_mode;

    localparam int AW = stl_pkg::QUEUE_AW;

    // lexer state
    t_mode                     r_mode, n_mode;
    logic                      r_quote_single, n_quote_single;
    logic                      r_bs_odd, n_bs_odd;
    logic                      r_prev_star, n_prev_star;
    logic                      r_frac_seen, n_frac_seen;
    logic [POSITION_BITS-1:0]  r_tok_start, n_tok_start;
    logic [POSITION_BITS-1:0]  r_pos, n_pos;
    logic [31:0]               r_tok_len, n_tok_len;

    // record queue
    stl_pkg::t_result          r_fifo [stl_pkg::QUEUE_DEPTH];
    logic [AW-1:0]             r_wr_ptr, r_rd_ptr;
    logic [AW:0]               r_count, n_count;

    logic                      accept, pop;

    // records of this character, in order: step close, step open, final x2
    stl_pkg::t_result          ev     [4];
    logic [3:0]                ev_vld;
    stl_pkg::t_result          res    [stl_pkg::MAX_RESULTS];
    logic [1:0]                res_cnt;

    logic [7:0]                c;
    logic [POSITION_BITS-1:0]  p1;
    logic [POSITION_BITS-1:0]  str_start;   // string text begins after the quote
    logic                      do_begin;
    logic                      handled;
    t_mode                     num_mode;

    function automatic stl_pkg::t_result mk(input stl_pkg::t_kind k,
                                            input logic [31:0] s,
                                            input logic [31:0] l,
                                            input logic [7:0] op);
        stl_pkg::t_result r;
        r.kind  = k;
        r.start = s;
        r.len   = l;
        r.op    = op;
        r.last  = 1'b0;
        return r;
    endfunction

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign pop    = o_m_axis_tvalid && i_m_axis_tready;

    // room for three new records once at most one is waiting
    assign o_s_axis_tready = (r_count <= (AW+1)'(1));

    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {r_fifo[r_rd_ptr].op, r_fifo[r_rd_ptr].len,
                              r_fifo[r_rd_ptr].start};
    assign o_m_axis_tuser  = r_fifo[r_rd_ptr].kind;
    assign o_m_axis_tlast  = r_fifo[r_rd_ptr].last;

    // next lexer state and records for the character on the input
    always_comb begin
        c              = i_s_axis_tdata;
        p1             = r_pos + POSITION_BITS'(1);
        str_start      = r_tok_start + POSITION_BITS'(1);
        n_mode         = r_mode;
        n_quote_single = r_quote_single;
        n_bs_odd       = r_bs_odd;
        n_prev_star    = r_prev_star;
        n_frac_seen    = r_frac_seen;
        n_tok_start    = r_tok_start;
        n_tok_len      = r_tok_len;
        n_pos          = r_pos;
        do_begin       = 1'b0;
        handled        = 1'b0;
        num_mode       = r_mode;
        for (int i = 0; i < 4; i++) begin
            ev[i] = mk(stl_pkg::K_IDENT, '0, '0, '0);
        end
        ev_vld = '0;

        case (r_mode)
            M_IDLE: begin
                do_begin = 1'b1;
            end
            M_SLASH: begin
                if (c == "/") begin
                    n_mode = M_LINE;
                end else if (c == "*") begin
                    n_mode      = M_BLOCK;
                    n_prev_star = 1'b0;
                    n_tok_len   = stl_pkg::sat_inc(r_tok_len);
                end else begin
                    ev[0]     = mk(stl_pkg::K_OPER, 32'(r_tok_start), 32'd1, 8'h2F);
                    ev_vld[0] = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            M_LINE: begin
                if (c == 8'h0A) begin
                    n_mode = M_IDLE;
                end
            end
            M_BLOCK: begin
                n_tok_len = stl_pkg::sat_inc(r_tok_len);
                if (r_prev_star && c == "/") begin
                    n_mode = M_IDLE;
                end else begin
                    n_prev_star = (c == "*");
                end
            end
            M_STRING: begin
                if (c == (r_quote_single ? 8'h27 : 8'h22) && !r_bs_odd) begin
                    ev[0]     = mk(stl_pkg::K_STRING, 32'(str_start), r_tok_len, '0);
                    ev_vld[0] = 1'b1;
                    n_mode    = M_IDLE;
                end else begin
                    n_tok_len = stl_pkg::sat_inc(r_tok_len);
                    n_bs_odd  = (c == 8'h5C) ? !r_bs_odd : 1'b0;
                end
            end
            M_IDENT: begin
                if (stl_pkg::is_term(c)) begin
                    ev[0]     = mk(stl_pkg::K_IDENT, 32'(r_tok_start), r_tok_len, '0);
                    ev_vld[0] = 1'b1;
                    do_begin  = 1'b1;
                end else begin
                    n_tok_len = stl_pkg::sat_inc(r_tok_len);
                end
            end
            default: begin
                // number modes
                if (r_mode == M_ZERO) begin
                    if (c == "x" || c == "X") begin
                        num_mode = M_HEX;
                        handled  = 1'b1;
                    end else if (c == "b" || c == "B") begin
                        num_mode = M_BIN;
                        handled  = 1'b1;
                    end else if (stl_pkg::is_oct(c)) begin
                        num_mode = M_OCT;
                        handled  = 1'b1;
                    end else begin
                        num_mode = M_DEC;
                    end
                end
                if (!handled) begin
                    case (num_mode)
                        M_HEX: handled = stl_pkg::is_hex(c);
                        M_BIN: handled = (c == "0" || c == "1");
                        M_OCT: begin
                            if (stl_pkg::is_oct(c)) begin
                                handled = 1'b1;
                            end else if (c == "8" || c == "9") begin
                                num_mode = M_DEC;
                                handled  = 1'b1;
                            end
                        end
                        M_DEC: begin
                            if (stl_pkg::is_dec(c)) begin
                                handled = 1'b1;
                            end else if (c == "." || c == "e") begin
                                n_frac_seen = (c == ".");
                                num_mode    = M_TAIL;
                                handled     = 1'b1;
                            end
                        end
                        default: begin
                            if (stl_pkg::is_dec(c)) begin
                                handled = 1'b1;
                            end else if (c == "e" && r_frac_seen) begin
                                n_frac_seen = 1'b0;
                                handled     = 1'b1;
                            end
                        end
                    endcase
                end
                n_mode = num_mode;
                if (handled) begin
                    n_tok_len = stl_pkg::sat_inc(r_tok_len);
                end else begin
                    ev[0]     = mk(stl_pkg::K_NUMBER, 32'(r_tok_start), r_tok_len, '0);
                    ev_vld[0] = 1'b1;
                    do_begin  = 1'b1;
                end
            end
        endcase

        // start of a new token, or skip whitespace
        if (do_begin) begin
            n_mode = M_IDLE;
            if (stl_pkg::is_space(c)) begin
                n_mode = M_IDLE;
            end else if (c == "/") begin
                n_mode      = M_SLASH;
                n_tok_start = r_pos;
                n_tok_len   = 32'd1;
            end else if (c == 8'h27 || c == 8'h22) begin
                n_mode         = M_STRING;
                n_tok_start    = r_pos;
                n_tok_len      = 32'd0;
                n_quote_single = (c == 8'h27);
                n_bs_odd       = 1'b0;
            end else if (stl_pkg::is_oper(c)) begin
                ev[1]     = mk(stl_pkg::K_OPER, 32'(r_pos), 32'd1, c);
                ev_vld[1] = 1'b1;
            end else if (stl_pkg::is_dec(c)) begin
                n_mode      = (c == "0") ? M_ZERO : M_DEC;
                n_tok_start = r_pos;
                n_tok_len   = 32'd1;
            end else if (c == "$" || c == "~") begin
                // stray terminator: one-character identifier
                ev[1]     = mk(stl_pkg::K_IDENT, 32'(r_pos), 32'd1, '0);
                ev_vld[1] = 1'b1;
            end else begin
                n_mode      = M_IDENT;
                n_tok_start = r_pos;
                n_tok_len   = 32'd1;
            end
        end

        // last character: close what is open, then back to reset state
        if (i_s_axis_tlast) begin
            case (n_mode)
                M_STRING: begin
                    ev[2]     = mk(stl_pkg::K_BADSTR, 32'(n_tok_start),
                                   stl_pkg::sat_inc(n_tok_len), '0);
                    ev_vld[2] = 1'b1;
                end
                M_BLOCK: begin
                    ev[2]     = mk(stl_pkg::K_BADCMT, 32'(n_tok_start), n_tok_len, '0);
                    ev_vld[2] = 1'b1;
                end
                M_SLASH: begin
                    ev[2]     = mk(stl_pkg::K_OPER, 32'(n_tok_start), 32'd1, 8'h2F);
                    ev_vld[2] = 1'b1;
                end
                M_IDENT: begin
                    ev[2]     = mk(stl_pkg::K_IDENT, 32'(n_tok_start), n_tok_len, '0);
                    ev_vld[2] = 1'b1;
                end
                M_IDLE, M_LINE: begin
                    ev_vld[2] = 1'b0;
                end
                default: begin
                    ev[2]     = mk(stl_pkg::K_NUMBER, 32'(n_tok_start), n_tok_len, '0);
                    ev_vld[2] = 1'b1;
                end
            endcase
            if (n_mode != M_STRING && n_mode != M_BLOCK) begin
                ev[3]     = mk(stl_pkg::K_END, 32'(p1), 32'd0, '0);
                ev_vld[3] = 1'b1;
            end
            n_mode         = M_IDLE;
            n_quote_single = 1'b0;
            n_bs_odd       = 1'b0;
            n_prev_star    = 1'b0;
            n_frac_seen    = 1'b0;
            n_tok_start    = '0;
            n_tok_len      = '0;
            n_pos          = '0;
        end else begin
            n_pos = p1;
        end

        // pack records in order, at most three
        res_cnt = '0;
        for (int i = 0; i < stl_pkg::MAX_RESULTS; i++) begin
            res[i] = mk(stl_pkg::K_IDENT, '0, '0, '0);
        end
        for (int i = 0; i < 4; i++) begin
            if (ev_vld[i] && res_cnt < 2'd3) begin
                res[res_cnt] = ev[i];
                res_cnt      = res_cnt + 2'd1;
            end
        end
        for (int i = 0; i < stl_pkg::MAX_RESULTS; i++) begin
            res[i].last = (2'(i + 1) == res_cnt);
        end
    end

    always_comb begin
        n_count = r_count - ((AW+1)'(pop));
        if (accept) begin
            n_count = n_count + (AW+1)'(res_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= M_IDLE;
            r_quote_single <= 1'b0;
            r_bs_odd       <= 1'b0;
            r_prev_star    <= 1'b0;
            r_frac_seen    <= 1'b0;
            r_tok_start    <= '0;
            r_pos          <= '0;
            r_tok_len      <= '0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            r_count <= n_count;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (accept) begin
                r_mode         <= n_mode;
                r_quote_single <= n_quote_single;
                r_bs_odd       <= n_bs_odd;
                r_prev_star    <= n_prev_star;
                r_frac_seen    <= n_frac_seen;
                r_tok_start    <= n_tok_start;
                r_pos          <= n_pos;
                r_tok_len      <= n_tok_len;
                r_wr_ptr       <= r_wr_ptr + AW'(res_cnt);
            end
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < stl_pkg::MAX_RESULTS; i++) begin
                if (2'(i) < res_cnt) begin
                    r_fifo[r_wr_ptr + AW'(i)] <= res[i];
                end
            end
        end
    end

endmodule
